/* design/peu_pkg.sv */
// Shared constants, register indexes and fixed-point helpers for the particle update pipe.
package peu_pkg;

  localparam int FRAC_BITS = 16;
  // Q7.8 config vectors widened to FRAC_BITS fractional bits
  localparam int VEC_SHIFT = FRAC_BITS - 8;
  localparam int VEC_W     = 16 + VEC_SHIFT;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIND    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLLIDE = 3'd5;

  localparam logic [15:0] DT_RST       = 16'd1092;
  localparam logic [15:0] BOUNCE_RST   = 16'd32768;
  localparam logic [15:0] FRICTION_Q16 = 16'd58982;  // 0.9 in Q0.16

  // product widths
  localparam int GP_W   = VEC_W + 17;  // gravity * dt
  localparam int DP_W   = 50;          // (wind - v) * kd, bounce / friction products
  localparam int PP_W   = 49;          // v * dt
  localparam int PROD_W = 51;          // common width for rounding
  localparam int RND_W  = 35;          // rounded product
  localparam int SUM_W  = 36;          // value plus rounded product

  // divide by 2^16, round to nearest, ties toward +inf
  function automatic logic signed [RND_W-1:0] rnd_q16(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] y;
    y = x + PROD_W'(32768);
    return y[PROD_W-1:16];
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
    logic ovf;
    ovf = (x[SUM_W-1:31] != {(SUM_W-31){1'b0}}) && (x[SUM_W-1:31] != {(SUM_W-31){1'b1}});
    if (ovf) begin
      return x[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return x[31:0];
  endfunction

  // one packed Q7.8 component, sign extended and aligned to FRAC_BITS
  function automatic logic signed [VEC_W-1:0] vec_comp(input logic [15:0] raw);
    logic signed [VEC_W-1:0] w;
    w = VEC_W'($signed(raw));
    return w <<< VEC_SHIFT;
  endfunction

endpackage

/* design/particle_euler_update.sv */
// Top level: eight-stage Euler update, one particle record per cycle unless stalled.
//
// Usage
//   Input channel (in_*): one particle record per transfer, taken at a rising
//   edge with in_valid high and in_stall low. Output channel (out_*): one
//   updated record per input, in order, taken when out_valid is high and
//   out_stall low. Config channel (cfg_*): cfg_ready is always high; a write
//   lands at the edge with cfg_valid high. Write config only while the
//   pipeline is empty.
//   Depth: eight register stages; a transferred record moves through them
//   in order, stage 1 to stage 8, and stage 8 drives the output ports.
//   Throughput: one record per cycle while out_stall is low, set by the
//   stage-per-multiply pipe (gravity, drag, position, ground bounce, each a
//   multiply then a round/add/saturate stage; bounce only rounds/saturates).
//   Stall: each stage holds only while it is full and the stage after it
//   holds, so a stalled output squeezes out bubbles first; in_stall rises
//   only once every stage is full. Nothing is dropped or repeated.
//   Reset (rst_n low, synchronous): all stage valid bits clear and the
//   config registers return to their defaults.
module particle_euler_update (
  input  logic                              clk,
  input  logic                              rst_n,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [peu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [peu_pkg::CFG_DAT_W-1:0]     cfg_data,
  // particle input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [31:0]                in_px,
  input  logic signed [31:0]                in_py,
  input  logic signed [31:0]                in_pz,
  input  logic signed [31:0]                in_vx,
  input  logic signed [31:0]                in_vy,
  input  logic signed [31:0]                in_vz,
  input  logic [31:0]                       in_age,
  input  logic [31:0]                       in_life_span,
  input  logic                              in_alive,
  // particle result
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                out_px,
  output logic signed [31:0]                out_py,
  output logic signed [31:0]                out_pz,
  output logic signed [31:0]                out_vx,
  output logic signed [31:0]                out_vy,
  output logic signed [31:0]                out_vz,
  output logic [31:0]                       out_age,
  output logic                              out_alive,
  output logic                              out_died_now
);

  localparam int NSTG = 8;

  // ---------------- config registers ----------------
  logic [47:0] gravity_r, wind_r;
  logic [15:0] drag_r, dt_r, bounce_r;
  logic        collide_en_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r    <= '0;
      wind_r       <= '0;
      drag_r       <= '0;
      dt_r         <= peu_pkg::DT_RST;
      bounce_r     <= peu_pkg::BOUNCE_RST;
      collide_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        peu_pkg::REG_GRAVITY: gravity_r    <= cfg_data[47:0];
        peu_pkg::REG_WIND:    wind_r       <= cfg_data[47:0];
        peu_pkg::REG_DRAG:    drag_r       <= cfg_data[15:0];
        peu_pkg::REG_DT:      dt_r         <= cfg_data[15:0];
        peu_pkg::REG_BOUNCE:  bounce_r     <= cfg_data[15:0];
        peu_pkg::REG_COLLIDE: collide_en_r <= cfg_data[0];
        default: ;  // unmapped index, write ignored
      endcase
    end
  end

  // ---------------- stage handshake ----------------
  // adv[i]: stage i register loads this cycle (empty, or its content moves on)
  logic [NSTG:1] vld_r;
  logic [NSTG:1] adv;

  always_comb begin
    adv[NSTG] = !vld_r[NSTG] || !out_stall;
    for (int i = NSTG - 1; i >= 1; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int i = 2; i <= NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  logic signed [17:0] dt_s;  // dt as a positive signed multiplier operand
  assign dt_s = $signed({2'b00, dt_r});

  // ---------------- stage 1: gravity * dt, drag * dt, age ----------------
  logic signed [31:0]               s1_p_r [3];
  logic signed [31:0]               s1_v_r [3];
  logic signed [peu_pkg::GP_W-1:0]  s1_gp_r [3];
  logic [31:0]                      s1_kdp_r, s1_age_r, s1_life_r;
  logic                             s1_live_r;

  logic signed [31:0]               s1_p_in [3];
  logic signed [31:0]               s1_v_in [3];
  logic signed [peu_pkg::GP_W-1:0]  s1_gp_nxt [3];
  logic [32:0]                      age_sum;
  logic [31:0]                      s1_age_nxt;

  assign s1_p_in = '{in_px, in_py, in_pz};
  assign s1_v_in = '{in_vx, in_vy, in_vz};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_gp_nxt[k] = peu_pkg::vec_comp(gravity_r[16*k +: 16]) * dt_s;
    end
    age_sum    = {1'b0, in_age} + {17'b0, dt_r};
    s1_age_nxt = in_alive ? (age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0]) : in_age;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int k = 0; k < 3; k++) begin
        s1_p_r[k]  <= s1_p_in[k];
        s1_v_r[k]  <= s1_v_in[k];
        s1_gp_r[k] <= s1_gp_nxt[k];
      end
      s1_kdp_r  <= 32'(drag_r) * 32'(dt_r);
      s1_age_r  <= s1_age_nxt;
      s1_life_r <= in_life_span;
      s1_live_r <= in_alive;
    end
  end

  // ---------------- stage 2: velocity += gravity, kd rounding, death ----------------
  logic signed [31:0] s2_p_r [3];
  logic signed [31:0] s2_v_r [3];
  logic [15:0]        s2_kd_r;
  logic [31:0]        s2_age_r;
  logic               s2_live_r, s2_alive_r, s2_died_r;

  logic signed [31:0] s2_v_nxt [3];
  logic [31:0]        kd_sum;
  logic               age_done;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_v_nxt[k] = s1_live_r
        ? peu_pkg::sat32(peu_pkg::SUM_W'(s1_v_r[k])
            + peu_pkg::SUM_W'(peu_pkg::rnd_q16(peu_pkg::PROD_W'(s1_gp_r[k]))))
        : s1_v_r[k];
    end
    kd_sum   = s1_kdp_r + 32'd32768;  // cannot wrap: max 65535^2 + 2^15 < 2^32
    age_done = s1_age_r >= s1_life_r;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int k = 0; k < 3; k++) begin
        s2_p_r[k] <= s1_p_r[k];
        s2_v_r[k] <= s2_v_nxt[k];
      end
      s2_kd_r    <= kd_sum[31:16];
      s2_age_r   <= s1_age_r;
      s2_live_r  <= s1_live_r;
      s2_alive_r <= s1_live_r && !age_done;
      s2_died_r  <= s1_live_r && age_done;
    end
  end

  // ---------------- stage 3: (wind - v) * kd ----------------
  logic signed [31:0]              s3_p_r [3];
  logic signed [31:0]              s3_v_r [3];
  logic signed [peu_pkg::DP_W-1:0] s3_dp_r [3];
  logic [31:0]                     s3_age_r;
  logic                            s3_live_r, s3_alive_r, s3_died_r;

  logic signed [32:0]              wdiff [3];
  logic signed [peu_pkg::DP_W-1:0] s3_dp_nxt [3];
  logic signed [16:0]              kd_s;

  assign kd_s = $signed({1'b0, s2_kd_r});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wdiff[k]     = 33'(peu_pkg::vec_comp(wind_r[16*k +: 16])) - 33'(s2_v_r[k]);
      s3_dp_nxt[k] = wdiff[k] * kd_s;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int k = 0; k < 3; k++) begin
        s3_p_r[k]  <= s2_p_r[k];
        s3_v_r[k]  <= s2_v_r[k];
        s3_dp_r[k] <= s3_dp_nxt[k];
      end
      s3_age_r   <= s2_age_r;
      s3_live_r  <= s2_live_r;
      s3_alive_r <= s2_alive_r;
      s3_died_r  <= s2_died_r;
    end
  end

  // ---------------- stage 4: velocity += drag ----------------
  logic signed [31:0] s4_p_r [3];
  logic signed [31:0] s4_v_r [3];
  logic [31:0]        s4_age_r;
  logic               s4_live_r, s4_alive_r, s4_died_r;

  logic signed [31:0] s4_v_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s4_v_nxt[k] = s3_live_r
        ? peu_pkg::sat32(peu_pkg::SUM_W'(s3_v_r[k])
            + peu_pkg::SUM_W'(peu_pkg::rnd_q16(peu_pkg::PROD_W'(s3_dp_r[k]))))
        : s3_v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int k = 0; k < 3; k++) begin
        s4_p_r[k] <= s3_p_r[k];
        s4_v_r[k] <= s4_v_nxt[k];
      end
      s4_age_r   <= s3_age_r;
      s4_live_r  <= s3_live_r;
      s4_alive_r <= s3_alive_r;
      s4_died_r  <= s3_died_r;
    end
  end

  // ---------------- stage 5: v * dt ----------------
  logic signed [31:0]              s5_p_r [3];
  logic signed [31:0]              s5_v_r [3];
  logic signed [peu_pkg::PP_W-1:0] s5_pp_r [3];
  logic [31:0]                     s5_age_r;
  logic                            s5_live_r, s5_alive_r, s5_died_r;

  logic signed [peu_pkg::PP_W-1:0] s5_pp_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s5_pp_nxt[k] = s4_v_r[k] * dt_s;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int k = 0; k < 3; k++) begin
        s5_p_r[k]  <= s4_p_r[k];
        s5_v_r[k]  <= s4_v_r[k];
        s5_pp_r[k] <= s5_pp_nxt[k];
      end
      s5_age_r   <= s4_age_r;
      s5_live_r  <= s4_live_r;
      s5_alive_r <= s4_alive_r;
      s5_died_r  <= s4_died_r;
    end
  end

  // ---------------- stage 6: position += v*dt, ground test ----------------
  logic signed [31:0] s6_p_r [3];
  logic signed [31:0] s6_v_r [3];
  logic [31:0]        s6_age_r;
  logic               s6_alive_r, s6_died_r, s6_hit_r;

  logic signed [31:0] s6_p_nxt [3];
  logic               s6_hit_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s6_p_nxt[k] = s5_live_r
        ? peu_pkg::sat32(peu_pkg::SUM_W'(s5_p_r[k])
            + peu_pkg::SUM_W'(peu_pkg::rnd_q16(peu_pkg::PROD_W'(s5_pp_r[k]))))
        : s5_p_r[k];
    end
    // bounce only with collide enabled, for a survivor of the age check below ground
    s6_hit_nxt = s5_alive_r && collide_en_r && s6_p_nxt[1][31];
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int k = 0; k < 3; k++) begin
        s6_p_r[k] <= s6_p_nxt[k];
        s6_v_r[k] <= s5_v_r[k];
      end
      s6_age_r   <= s5_age_r;
      s6_alive_r <= s5_alive_r;
      s6_died_r  <= s5_died_r;
      s6_hit_r   <= s6_hit_nxt;
    end
  end

  // ---------------- stage 7: bounce and friction products ----------------
  logic signed [31:0]              s7_p_r [3];
  logic signed [31:0]              s7_v_r [3];
  logic signed [peu_pkg::DP_W-1:0] s7_m_r [3];
  logic [31:0]                     s7_age_r;
  logic                            s7_alive_r, s7_died_r, s7_hit_r;

  logic signed [32:0]              m_op [3];
  logic signed [16:0]              m_coef [3];
  logic signed [peu_pkg::DP_W-1:0] s7_m_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_op[k]   = 33'(s6_v_r[k]);
      m_coef[k] = $signed({1'b0, peu_pkg::FRICTION_Q16});
    end
    // vertical: reflect and damp
    m_op[1]   = -(33'(s6_v_r[1]));
    m_coef[1] = $signed({1'b0, bounce_r});
    for (int k = 0; k < 3; k++) begin
      s7_m_nxt[k] = m_op[k] * m_coef[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      for (int k = 0; k < 3; k++) begin
        s7_p_r[k] <= s6_p_r[k];
        s7_v_r[k] <= s6_v_r[k];
        s7_m_r[k] <= s7_m_nxt[k];
      end
      s7_age_r   <= s6_age_r;
      s7_alive_r <= s6_alive_r;
      s7_died_r  <= s6_died_r;
      s7_hit_r   <= s6_hit_r;
    end
  end

  // ---------------- stage 8: ground response, output register ----------------
  logic signed [31:0] s8_p_r [3];
  logic signed [31:0] s8_v_r [3];
  logic [31:0]        s8_age_r;
  logic               s8_alive_r, s8_died_r;

  logic signed [31:0] s8_p_nxt [3];
  logic signed [31:0] s8_v_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s8_p_nxt[k] = s7_p_r[k];
      s8_v_nxt[k] = s7_hit_r
        ? peu_pkg::sat32(peu_pkg::SUM_W'(peu_pkg::rnd_q16(peu_pkg::PROD_W'(s7_m_r[k]))))
        : s7_v_r[k];
    end
    if (s7_hit_r) begin
      s8_p_nxt[1] = '0;  // clamp to ground plane
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      for (int k = 0; k < 3; k++) begin
        s8_p_r[k] <= s8_p_nxt[k];
        s8_v_r[k] <= s8_v_nxt[k];
      end
      s8_age_r   <= s7_age_r;
      s8_alive_r <= s7_alive_r;
      s8_died_r  <= s7_died_r;
    end
  end

  assign out_valid    = vld_r[NSTG];
  assign out_px       = s8_p_r[0];
  assign out_py       = s8_p_r[1];
  assign out_pz       = s8_p_r[2];
  assign out_vx       = s8_v_r[0];
  assign out_vy       = s8_v_r[1];
  assign out_vz       = s8_v_r[2];
  assign out_age      = s8_age_r;
  assign out_alive    = s8_alive_r;
  assign out_died_now = s8_died_r;

endmodule

/* design/peu_checker.sv */
// Port-level checker for the particle update pipe, bound to the top level.
module peu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_px,
  input logic signed [31:0] out_py,
  input logic signed [31:0] out_vy,
  input logic [31:0]        out_age,
  input logic               out_alive,
  input logic               out_died_now
);

  // synchronous reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // a free output means every stage can move, so the input never backs up
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("in_stall raised while output is free");

  // a particle that died this step is never reported alive
  a_died_not_alive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_died_now |-> !out_alive)
    else $error("died_now together with alive");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_px) && $stable(out_py) && $stable(out_vy)
      && $stable(out_age) && $stable(out_alive) && $stable(out_died_now))
    else $error("stalled result changed");

endmodule

bind particle_euler_update peu_checker u_peu_checker (.*);
